// File: sv/pd132_pkg.sv
// Shared types and constants for the 132-pattern detector.
package pd132_pkg;

   localparam int STACK_DEPTH_DEF = 256;
   localparam int MAX_LEN_DEF     = 65536;
   localparam int VALUE_BITS_DEF  = 32;

   // Result word layout, lowest bit up.
   localparam int PG_W         = 17;
   localparam int RSP_FOUND_B  = 0;
   localparam int RSP_HIT_B    = 1;
   localparam int RSP_PG_LSB   = 2;
   localparam int RSP_PG_MSB   = RSP_PG_LSB + PG_W - 1;
   localparam int RSP_OVF_B    = RSP_PG_MSB + 1;
   localparam int RSP_DATA_W   = ((RSP_OVF_B + 1 + 7) / 8) * 8;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_SCAN
   } state_type;

   typedef struct packed {
      logic load;
      logic pop;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic pop_need;
   } status_type;

endpackage

// File: sv/pd132_ctrl.sv
// Sequencer for the 132-pattern detector: accept, pop loop, commit.
module pd132_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output pd132_pkg::cmd_type    cmd,
   input  pd132_pkg::status_type status
);

   pd132_pkg::state_type state_ff, state_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pd132_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         pd132_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = pd132_pkg::ST_SCAN;
            end
         end
         pd132_pkg::ST_SCAN: begin
            if (status.pop_need) begin
               cmd.pop = 1'b1;
            end else if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = pd132_pkg::ST_IDLE;
            end
         end
         default: state_in = pd132_pkg::ST_IDLE;
      endcase
      // Hold the result word until taken; a commit refills it.
      rsp_valid_in = cmd.commit || (rsp_valid_ff && !rsp_tready);
   end

endmodule

// File: sv/pd132_dpath.sv
// Datapath: stack memory with cached top, prefix minimum, flags, result word.
module pd132_dpath #(
   parameter int STACK_DEPTH = pd132_pkg::STACK_DEPTH_DEF,
   parameter int MAX_LEN     = pd132_pkg::MAX_LEN_DEF,
   parameter int VALUE_BITS  = pd132_pkg::VALUE_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  pd132_pkg::cmd_type               cmd,
   output pd132_pkg::status_type            status,
   input  logic [VALUE_BITS-1:0]            req_value,
   input  logic                             req_first,
   input  logic                             req_last,
   output logic [pd132_pkg::RSP_DATA_W-1:0] rsp_data,
   output logic                             rsp_last
);

   localparam int AW  = $clog2(STACK_DEPTH);
   localparam int CW  = $clog2(STACK_DEPTH + 1);
   localparam int PW  = $clog2(MAX_LEN);
   localparam int PCW = $clog2(MAX_LEN + 1);
   localparam int EW  = 2 * VALUE_BITS + PW;

   // Entry layout: {value, min_before, position}.
   logic [EW-1:0] stack_ff [STACK_DEPTH];
   logic [EW-1:0] top_ff, top_in;
   logic [EW-1:0] below_ff;

   logic signed [VALUE_BITS-1:0] value_ff, value_in;
   logic signed [VALUE_BITS-1:0] prefix_min_ff, prefix_min_in;
   logic                         last_ff, last_in;
   logic [CW-1:0]                count_ff, count_in;
   logic [PCW-1:0]               pos_ff, pos_in;
   logic                         found_ff, found_in;
   logic                         ovf_ff, ovf_in;
   logic [pd132_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                         rsp_last_ff, rsp_last_in;

   logic signed [VALUE_BITS-1:0] top_val, top_min, earlier_min;
   logic [PW-1:0]                top_pos;
   logic                         pos_full, stack_any, push, hit;
   logic [pd132_pkg::PG_W-1:0]   pg;
   logic [AW-1:0]                rd_addr, wr_addr;

   assign top_val = $signed(top_ff[EW-1 -: VALUE_BITS]);
   assign top_min = $signed(top_ff[PW +: VALUE_BITS]);
   assign top_pos = top_ff[PW-1:0];

   assign pos_full  = (pos_ff == PCW'(MAX_LEN));
   assign stack_any = (count_ff != '0);
   assign status.pop_need = !pos_full && stack_any && (top_val <= value_ff);

   assign rsp_data = rsp_data_ff;
   assign rsp_last = rsp_last_ff;

   always_comb begin
      value_in      = value_ff;
      last_in       = last_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      found_in      = found_ff;
      ovf_in        = ovf_ff;
      prefix_min_in = prefix_min_ff;
      top_in        = top_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;
      push          = 1'b0;
      hit           = 1'b0;
      pg            = '1;
      earlier_min   = (pos_ff == '0) ? '0 : prefix_min_ff;

      if (cmd.load) begin
         value_in = $signed(req_value);
         last_in  = req_last;
         if (req_first) begin
            count_in = '0;
            pos_in   = '0;
            found_in = 1'b0;
            ovf_in   = 1'b0;
         end
      end

      if (cmd.pop) begin
         count_in = count_ff - CW'(1);
         top_in   = below_ff;
      end

      if (cmd.commit) begin
         if (pos_full) begin
            ovf_in = 1'b1;
         end else begin
            if (stack_any) begin
               pg  = pd132_pkg::PG_W'(top_pos);
               hit = (top_pos != '0) && (top_min < value_ff) && (value_ff < top_val);
            end
            if (count_ff < CW'(STACK_DEPTH)) begin
               push     = 1'b1;
               count_in = count_ff + CW'(1);
               top_in   = {value_ff, earlier_min, PW'(pos_ff)};
            end else begin
               ovf_in = 1'b1;
            end
            if (pos_ff == '0 || value_ff < prefix_min_ff) begin
               prefix_min_in = value_ff;
            end
            pos_in   = pos_ff + PCW'(1);
            found_in = found_ff || hit;
         end
         rsp_data_in = '0;
         rsp_data_in[pd132_pkg::RSP_FOUND_B] = found_in;
         rsp_data_in[pd132_pkg::RSP_HIT_B]   = hit;
         rsp_data_in[pd132_pkg::RSP_PG_MSB:pd132_pkg::RSP_PG_LSB] = pg;
         rsp_data_in[pd132_pkg::RSP_OVF_B]   = ovf_in;
         rsp_last_in = last_ff;
      end
   end

   // Entry below the top sits at count - 2 after this edge.
   assign rd_addr = AW'(count_in - CW'(2));
   assign wr_addr = AW'(count_ff - CW'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         pos_ff   <= '0;
         found_ff <= 1'b0;
         ovf_ff   <= 1'b0;
      end else begin
         count_ff <= count_in;
         pos_ff   <= pos_in;
         found_ff <= found_in;
         ovf_ff   <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff      <= value_in;
      last_ff       <= last_in;
      prefix_min_ff <= prefix_min_in;
      top_ff        <= top_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // Stack body below the cached top; bypass the old top on a push.
   always_ff @(posedge clock) begin
      if (push && stack_any) begin
         stack_ff[wr_addr] <= top_ff;
      end
      if (push) begin
         below_ff <= top_ff;
      end else begin
         below_ff <= stack_ff[rd_addr];
      end
   end

endmodule

// File: sv/pattern_132_detector.sv
// Top level of the streaming 132-pattern detector.
// Flow: after a word is accepted, the value pops every stack entry whose value
//   is not greater than it, then commits once the result register is free.
// A new word is accepted only after the previous commit; each value is popped
//   at most once. The pop loop and result back-pressure are the limit.
// Reset: synchronous; clears stack count, position, flags and result valid.
//   Stack memory is not cleared.
module pattern_132_detector #(
   parameter int STACK_DEPTH = pd132_pkg::STACK_DEPTH_DEF,
   parameter int MAX_LEN     = pd132_pkg::MAX_LEN_DEF,
   parameter int VALUE_BITS  = pd132_pkg::VALUE_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [((VALUE_BITS + 7) / 8) * 8-1:0] req_tdata,  // value
   input  logic                                  req_tuser,  // first
   input  logic                                  req_tlast,  // last
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // found, hit_here, prev_greater_pos[16:0], overflow, zero pad
   output logic [pd132_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                  rsp_tlast   // end_of_sequence
);

   pd132_pkg::cmd_type    cmd;
   pd132_pkg::status_type status;

   pd132_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   pd132_dpath #(
      .STACK_DEPTH (STACK_DEPTH),
      .MAX_LEN     (MAX_LEN),
      .VALUE_BITS  (VALUE_BITS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_value (req_tdata[VALUE_BITS-1:0]),
      .req_first (req_tuser),
      .req_last  (req_tlast),
      .rsp_data  (rsp_tdata),
      .rsp_last  (rsp_tlast)
   );

endmodule

// File: sv/pd132_checker.sv
// Port-level checks for the 132-pattern detector and their binding.
module pd132_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [pd132_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                             rsp_tlast
);

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result word changed");

   a_hit_found: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[pd132_pkg::RSP_HIT_B] |->
         rsp_tdata[pd132_pkg::RSP_FOUND_B])
      else $error("hit without sticky found");

   a_none_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[pd132_pkg::RSP_PG_MSB] |->
         (rsp_tdata[pd132_pkg::RSP_PG_MSB:pd132_pkg::RSP_PG_LSB] == '1) &&
         !rsp_tdata[pd132_pkg::RSP_HIT_B])
      else $error("bad no-greater position or hit without greater element");

endmodule

bind pattern_132_detector pd132_checker u_pd132_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
